[design/thpc_pkg.sv]
// shared types and constants of the triac heater phase controller
`default_nettype none

package thpc_pkg;

  typedef enum logic [2:0] {
    OP_ENCODER    = 3'd0,
    OP_TEMP       = 3'd1,
    OP_TICK       = 3'd2,
    OP_ZERO_CROSS = 3'd3,
    OP_US_TICK    = 3'd4
  } op_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_STEP = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_STEP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MIN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MAX     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MAX  = 3'd4;

  localparam logic [5:0]  RST_SETPOINT_STEP = 6'd5;
  localparam logic [6:0]  RST_DELAY_STEP    = 7'd5;
  localparam logic [13:0] RST_DELAY_MIN     = 14'd500;
  localparam logic [13:0] RST_DELAY_MAX     = 14'd9300;
  localparam logic [8:0]  RST_SETPOINT_MAX  = 9'd300;

  localparam logic [8:0]  RST_SETPOINT      = 9'd60;
  localparam int unsigned RST_DELAY_VALUE   = 500;

  // encoder pin patterns
  localparam logic [1:0] AB_IDLE = 2'b00;
  localparam logic [1:0] AB_UP   = 2'b01;
  localparam logic [1:0] AB_DOWN = 2'b10;
  localparam logic [1:0] AB_BOTH = 2'b11;

  localparam int unsigned TEMP_SPAN = 400;
  localparam int unsigned ADC_FULL  = 1023;

  typedef struct packed {
    logic [5:0]  setpoint_step;
    logic [6:0]  delay_step;
    logic [13:0] delay_min;
    logic [13:0] delay_max;
    logic [8:0]  setpoint_max;
  } cfg_t;

  // result fields before the digit split
  typedef struct packed {
    logic        triac_gate;
    logic [13:0] firing_delay;
    logic [8:0]  target_temp;
    logic [8:0]  shown_value;
  } res_t;

endpackage

`default_nettype wire

[design/triac_heater_phase_controller.sv]
// top level of the triac heater phase controller
`default_nettype none

// Heater controller with a triac phase-angle gate. Each input transaction is
// one event: encoder sample, temperature sample, control tick, mains zero cross
// or microsecond tick, selected by s_tuser. Every event yields exactly one
// result transaction with the gate level, firing delay, setpoint and display
// value with its decimal digits, all taken after the event is applied. An event
// is applied in the cycle it is accepted and its result appears on the master
// side the next cycle; one transaction per cycle is sustained, limited only by
// the single result register, which frees as soon as the result is taken.
// Configuration writes are accepted every cycle and should be made while idle.
module triac_heater_phase_controller #(
  parameter int unsigned DELAY_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // encoder_ab[1:0], adc_sample[11:2], zeros
  input  wire logic [2:0]  s_tuser,   // operation[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // triac_gate[0], firing_delay[14:1], target_temp[23:15], shown_value[32:24],
  // digit_hundreds[35:33], digit_tens[39:36], digit_units[43:40], zeros
  output logic [47:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [thpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [thpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import thpc_pkg::*;

  cfg_t cfg;
  res_t res_next;
  logic in_take;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_take   = s_tvalid && s_tready;

  thpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  thpc_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (in_take),
    .operation  (s_tuser),
    .encoder_ab (s_tdata[1:0]),
    .adc_sample (s_tdata[11:2]),
    .cfg        (cfg),
    .res_next   (res_next)
  );

  thpc_outreg u_outreg (
    .clk    (clk),
    .rst    (rst),
    .load   (in_take),
    .res_in (res_next),
    .take   (m_tready),
    .full   (m_tvalid),
    .data   (m_tdata)
  );

endmodule

`default_nettype wire

[design/thpc_cfg.sv]
// configuration register file of the heater controller
`default_nettype none

module thpc_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [thpc_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  wire logic [thpc_pkg::CFG_DATA_W-1:0]    wr_data,
  output thpc_pkg::cfg_t                          cfg
);
  import thpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_step <= RST_SETPOINT_STEP;
      cfg.delay_step    <= RST_DELAY_STEP;
      cfg.delay_min     <= RST_DELAY_MIN;
      cfg.delay_max     <= RST_DELAY_MAX;
      cfg.setpoint_max  <= RST_SETPOINT_MAX;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SETPOINT_STEP: cfg.setpoint_step <= wr_data[5:0];
        CFG_DELAY_STEP:    cfg.delay_step    <= wr_data[6:0];
        CFG_DELAY_MIN:     cfg.delay_min     <= wr_data[13:0];
        CFG_DELAY_MAX:     cfg.delay_max     <= wr_data[13:0];
        CFG_SETPOINT_MAX:  cfg.setpoint_max  <= wr_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/thpc_core.sv]
// controller state and its update for one transaction
`default_nettype none

module thpc_core #(
  parameter int unsigned DELAY_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [2:0]  operation,
  input  wire logic [1:0]  encoder_ab,
  input  wire logic [9:0]  adc_sample,
  input  wire thpc_pkg::cfg_t cfg,
  output thpc_pkg::res_t   res_next
);
  import thpc_pkg::*;

  // compare width wide enough for either the delay or a 14-bit bound, plus a carry bit and a sign bit
  localparam int unsigned CW = ((DELAY_BITS > 14) ? DELAY_BITS : 14) + 2;
  localparam logic [CW-1:0] DMASK = CW'((64'd1 << DELAY_BITS) - 64'd1);

  logic [8:0]            setpoint;
  logic [8:0]            measured_temp;
  logic [DELAY_BITS-1:0] delay_value;
  logic                  setpoint_changed;
  logic                  detent_armed;
  logic [1:0]            last_ab;
  logic [DELAY_BITS-1:0] countdown;
  logic                  timer_running;
  logic                  gate_level;
  logic [8:0]            display_hold;

  logic [8:0]            setpoint_next;
  logic [8:0]            measured_temp_next;
  logic [DELAY_BITS-1:0] delay_value_next;
  logic                  setpoint_changed_next;
  logic                  detent_armed_next;
  logic [1:0]            last_ab_next;
  logic [DELAY_BITS-1:0] countdown_next;
  logic                  timer_running_next;
  logic                  gate_level_next;
  logic [8:0]            display_hold_next;

  // setpoint stepping
  logic signed [10:0] sp_prev;
  logic signed [10:0] sp_stepped;
  logic [8:0]         sp_clamped;

  // temperature scaling: x*400/1023 via shift and one correction
  logic [18:0] adc_scaled;
  logic [8:0]  temp_est;
  logic [10:0] temp_rem;
  logic [8:0]  temp_value;

  // delay stepping
  logic signed [CW-1:0] d_cur;
  logic signed [CW-1:0] d_step;
  logic signed [CW-1:0] d_moved;
  logic [CW-1:0]        lo_bound;
  logic [CW-1:0]        hi_bound;
  logic [CW-1:0]        d_clamped;

  logic [DELAY_BITS-1:0] cd_dec;

  always_comb begin
    sp_prev = $signed({2'b00, setpoint});
    if (last_ab == AB_UP) begin
      sp_stepped = sp_prev + $signed({5'b00000, cfg.setpoint_step});
    end else if (last_ab == AB_DOWN) begin
      sp_stepped = sp_prev - $signed({5'b00000, cfg.setpoint_step});
    end else begin
      sp_stepped = sp_prev;
    end
    if (sp_stepped < 0) begin
      sp_clamped = '0;
    end else if (sp_stepped > $signed({2'b00, cfg.setpoint_max})) begin
      sp_clamped = cfg.setpoint_max;
    end else begin
      sp_clamped = sp_stepped[8:0];
    end
  end

  always_comb begin
    adc_scaled = 19'(adc_sample) * 19'(TEMP_SPAN);
    temp_est   = adc_scaled[18:10];
    temp_rem   = {1'b0, adc_scaled[9:0]} + {2'b00, temp_est};
    temp_value = (temp_rem >= 11'(ADC_FULL)) ? temp_est + 9'd1 : temp_est;
  end

  always_comb begin
    d_cur  = $signed(CW'(delay_value));
    d_step = $signed(CW'(cfg.delay_step));
    if (setpoint < measured_temp) begin
      d_moved = d_cur + d_step;
    end else if (setpoint > measured_temp) begin
      d_moved = d_cur - d_step;
    end else begin
      d_moved = d_cur;
    end
    lo_bound = (CW'(cfg.delay_min) > DMASK) ? DMASK : CW'(cfg.delay_min);
    hi_bound = (CW'(cfg.delay_max) > DMASK) ? DMASK : CW'(cfg.delay_max);
    if (d_moved < $signed(lo_bound)) begin
      d_clamped = lo_bound;
    end else if (d_moved > $signed(hi_bound)) begin
      d_clamped = hi_bound;
    end else begin
      d_clamped = d_moved;
    end
  end

  assign cd_dec = countdown - DELAY_BITS'(1);

  always_comb begin
    setpoint_next         = setpoint;
    measured_temp_next    = measured_temp;
    delay_value_next      = delay_value;
    setpoint_changed_next = setpoint_changed;
    detent_armed_next     = detent_armed;
    last_ab_next          = last_ab;
    countdown_next        = countdown;
    timer_running_next    = timer_running;
    gate_level_next       = gate_level;
    display_hold_next     = display_hold;
    case (op_t'(operation))
      OP_ENCODER: begin
        if (detent_armed && encoder_ab == AB_BOTH) begin
          setpoint_next     = sp_clamped;
          detent_armed_next = 1'b0;
          if (sp_stepped != sp_prev) begin
            setpoint_changed_next = 1'b1;
          end
        end
        if (encoder_ab == AB_IDLE) begin
          detent_armed_next = 1'b1;
        end
        last_ab_next = encoder_ab;
      end
      OP_TEMP: begin
        measured_temp_next = temp_value;
      end
      OP_TICK: begin
        delay_value_next = d_clamped[DELAY_BITS-1:0];
        if (setpoint_changed) begin
          display_hold_next     = setpoint;
          setpoint_changed_next = 1'b0;
        end else begin
          display_hold_next = measured_temp;
        end
      end
      OP_ZERO_CROSS: begin
        gate_level_next    = 1'b0;
        countdown_next     = (delay_value == '0) ? DELAY_BITS'(1) : delay_value;
        timer_running_next = 1'b1;
      end
      OP_US_TICK: begin
        if (timer_running) begin
          countdown_next = cd_dec;
          if (cd_dec == '0) begin
            gate_level_next    = 1'b1;
            timer_running_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= RST_SETPOINT;
      measured_temp    <= '0;
      delay_value      <= DELAY_BITS'(RST_DELAY_VALUE);
      setpoint_changed <= 1'b0;
      detent_armed     <= 1'b0;
      last_ab          <= '0;
      countdown        <= '0;
      timer_running    <= 1'b0;
      gate_level       <= 1'b0;
      display_hold     <= '0;
    end else if (step) begin
      setpoint         <= setpoint_next;
      measured_temp    <= measured_temp_next;
      delay_value      <= delay_value_next;
      setpoint_changed <= setpoint_changed_next;
      detent_armed     <= detent_armed_next;
      last_ab          <= last_ab_next;
      countdown        <= countdown_next;
      timer_running    <= timer_running_next;
      gate_level       <= gate_level_next;
      display_hold     <= display_hold_next;
    end
  end

  always_comb begin
    res_next.triac_gate   = gate_level_next;
    res_next.firing_delay = 14'(delay_value_next);
    res_next.target_temp  = setpoint_next;
    res_next.shown_value  = display_hold_next;
  end

endmodule

`default_nettype wire

[design/thpc_outreg.sv]
// result register with decimal digit split of the shown value
`default_nettype none

module thpc_outreg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire thpc_pkg::res_t res_in,
  input  wire logic        take,
  output logic             full,
  output logic [47:0]      data
);
  import thpc_pkg::*;

  logic [16:0] tens_prod;
  logic [14:0] hund_prod;
  logic [5:0]  q_tens;
  logic [2:0]  hundreds;
  logic [3:0]  tens;
  logic [3:0]  units;

  // reciprocal multiplies, exact for values below 512
  always_comb begin
    tens_prod = 17'(res_in.shown_value) * 17'd205;
    hund_prod = 15'(res_in.shown_value) * 15'd41;
    q_tens    = tens_prod[16:11];
    hundreds  = hund_prod[14:12];
    tens      = 4'(q_tens - 6'(hundreds) * 6'd10);
    units     = 4'(res_in.shown_value - 9'(q_tens) * 9'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= {4'b0000, units, tens, hundreds, res_in.shown_value,
               res_in.target_temp, res_in.firing_delay, res_in.triac_gate};
    end
  end

endmodule

`default_nettype wire
